// ===== src/pctr_pkg.sv =====
// Shared types, constants and register codes for the pulse-count temperature reader.
package pctr_pkg;

  localparam int SENSORS_DEF    = 8;
  localparam int TIMER_BITS_DEF = 16;

  localparam logic [15:0] FIRST_PULSE_RST = 16'd50000;
  localparam logic [15:0] GAP_RST         = 16'd11;
  localparam logic [11:0] MAX_COUNT_RST   = 12'd3201;
  localparam logic [1:0]  UNIT_RST        = 2'd0;

  localparam logic [11:0] FULL_SCALE = 12'd3201;

  localparam logic signed [12:0] COUNT_OFFSET = 13'sd801;
  localparam logic signed [12:0] LOW_KNEE     = 13'sd480;
  localparam logic signed [12:0] HIGH_LO      = 13'sd1600;
  localparam logic signed [12:0] HIGH_HI      = 13'sd2400;

  localparam logic signed [11:0] K_LOW  = 12'sd1005;
  localparam logic signed [11:0] K_HIGH = 12'sd988;
  localparam logic signed [11:0] K_MID  = 12'sd1000;
  localparam logic signed [23:0] OFF_LOW  = -24'sd2400;
  localparam logic signed [23:0] OFF_HIGH = 24'sd19200;

  localparam logic signed [31:0] A_CK      = 32'sd10;
  localparam logic signed [31:0] A_F       = 32'sd18;
  localparam logic signed [31:0] B_F       = 32'sd5120000;
  localparam logic signed [31:0] B_K       = 32'sd43704000;
  // rounding half of the divisor plus a bias of 32768 divisors keeps the dividend positive
  localparam logic signed [31:0] DIV_BIAS  = 32'sd20480312;

  localparam int             DVD_W     = 27;
  // ceil(2^36 / 625): exact floor division by 625 for any dividend below 2^27
  localparam logic signed [28:0] DIV_RECIP = 29'sd109951163;
  localparam int             DIV_SHIFT = 36;
  localparam logic [18:0]    QUOT_BIAS = 19'd32768;
  localparam logic [18:0]    FAULT_TEMP = 19'd256000;

  typedef enum logic [1:0] {
    REG_FIRST_PULSE = 2'd0,
    REG_GAP         = 2'd1,
    REG_MAX_COUNT   = 2'd2,
    REG_UNIT        = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    UNIT_C = 2'd0,
    UNIT_F = 2'd1,
    UNIT_K = 2'd2
  } unit_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WAIT  = 3'b010,
    PH_COUNT = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]  mask;
    logic        busy;
    logic        done;
    logic        fault;
    logic [11:0] count;
  } tick_t;

endpackage

// ===== src/pctr_ctrl.sv =====
// Tick sequencer: phase, pulse counter and wait timer of one measurement.
module pctr_ctrl #(
  parameter int SENSORS    = pctr_pkg::SENSORS_DEF,
  parameter int TIMER_BITS = pctr_pkg::TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick_en,
  input  logic                 start_req,
  input  logic [2:0]           sensor_index,
  input  logic                 pulse_edge,
  input  logic [15:0]          first_pulse_ticks,
  input  logic [15:0]          gap_ticks,
  input  logic [11:0]          max_count,
  output pctr_pkg::tick_t      tick
);

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;
  localparam logic [CW-1:0] TMAX_EXT = CW'(TMAX);

  pctr_pkg::phase_t        phase_r, phase_nxt;
  logic [11:0]             count_r, count_nxt;
  logic [TIMER_BITS-1:0]   timer_r, timer_nxt;
  logic [2:0]              sensor_r, sensor_nxt;

  logic                    finish, flt;
  logic [TIMER_BITS-1:0]   timer_inc;
  logic [CW-1:0]           lim_raw, lim;
  logic [7:0]              mask;

  always_comb begin
    lim_raw = CW'((phase_r == pctr_pkg::PH_WAIT) ? first_pulse_ticks : gap_ticks);
    lim = (lim_raw > TMAX_EXT) ? TMAX_EXT : lim_raw;
    if (lim == '0) begin
      lim = CW'(1);
    end
    timer_inc = (timer_r != TMAX) ? timer_r + 1'b1 : timer_r;
  end

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    timer_nxt  = timer_r;
    sensor_nxt = sensor_r;
    finish     = 1'b0;
    flt        = 1'b0;
    unique case (phase_r)
      pctr_pkg::PH_WAIT, pctr_pkg::PH_COUNT: begin
        if (pulse_edge) begin
          count_nxt = count_r + 1'b1;
          timer_nxt = '0;
          phase_nxt = pctr_pkg::PH_COUNT;
          finish    = (count_nxt >= max_count);
        end else begin
          timer_nxt = timer_inc;
          if (CW'(timer_inc) >= lim) begin
            finish = 1'b1;
            flt    = (phase_r == pctr_pkg::PH_WAIT);
          end
        end
      end
      default: begin
        phase_nxt = pctr_pkg::PH_IDLE;
        if (start_req) begin
          sensor_nxt = sensor_index;
          count_nxt  = '0;
          timer_nxt  = '0;
          phase_nxt  = pctr_pkg::PH_WAIT;
        end
      end
    endcase
    if (finish) begin
      if (count_nxt == '0 || count_nxt > pctr_pkg::FULL_SCALE) begin
        flt = 1'b1;
      end
      phase_nxt = pctr_pkg::PH_IDLE;
    end
  end

  always_comb begin
    mask = '0;
    if ({29'd0, sensor_nxt} < 32'(SENSORS)) begin
      mask = 8'd1 << sensor_nxt;
    end
    tick.busy  = (phase_nxt != pctr_pkg::PH_IDLE);
    tick.mask  = tick.busy ? mask : '0;
    tick.done  = finish;
    tick.fault = flt;
    tick.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pctr_pkg::PH_IDLE;
      count_r  <= '0;
      timer_r  <= '0;
      sensor_r <= '0;
    end else if (tick_en) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      timer_r  <= timer_nxt;
      sensor_r <= sensor_nxt;
    end
  end

endmodule

// ===== src/pctr_conv.sv =====
// Count to temperature converter: scaling, unit and reciprocal divide on one shared multiplier.
module pctr_conv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] count,
  input  logic [1:0]  unit_select,
  output logic        done,
  output logic [18:0] temperature
);

  typedef enum logic [3:0] {
    CV_IDLE  = 4'b0001,
    CV_MUL   = 4'b0010,
    CV_SCALE = 4'b0100,
    CV_DIV   = 4'b1000
  } cv_state_t;

  cv_state_t                     st_r, st_nxt;
  logic [11:0]                   count_r;
  logic [1:0]                    unit_r;
  logic signed [23:0]            big_r;
  logic [pctr_pkg::DVD_W-1:0]    dvd_r;
  logic [18:0]                   quot_r;
  logic                          done_r;

  logic signed [12:0]            n;
  logic signed [11:0]            k;
  logic signed [23:0]            off;
  logic signed [31:0]            a, b, scaled;
  logic signed [28:0]            mul_a, mul_b;
  logic signed [57:0]            mul_p;

  always_comb begin
    n = $signed({1'b0, count_r}) - pctr_pkg::COUNT_OFFSET;
    if (n < pctr_pkg::LOW_KNEE) begin
      k   = pctr_pkg::K_LOW;
      off = pctr_pkg::OFF_LOW;
    end else if (n > pctr_pkg::HIGH_LO && n < pctr_pkg::HIGH_HI) begin
      k   = pctr_pkg::K_HIGH;
      off = pctr_pkg::OFF_HIGH;
    end else begin
      k   = pctr_pkg::K_MID;
      off = '0;
    end

    a = pctr_pkg::A_CK;
    b = '0;
    if (unit_r == pctr_pkg::UNIT_F) begin
      a = pctr_pkg::A_F;
      b = pctr_pkg::B_F;
    end else if (unit_r == pctr_pkg::UNIT_K) begin
      b = pctr_pkg::B_K;
    end

    unique case (st_r)
      CV_MUL: begin
        mul_a = 29'(n);
        mul_b = 29'(k);
      end
      CV_SCALE: begin
        mul_a = 29'(big_r);
        mul_b = 29'(a);
      end
      CV_DIV: begin
        mul_a = $signed({2'b00, dvd_r});
        mul_b = pctr_pkg::DIV_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p  = 58'(mul_a) * 58'(mul_b);
    scaled = 32'(mul_p) + b + pctr_pkg::DIV_BIAS;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      CV_IDLE:  if (start) st_nxt = CV_MUL;
      CV_MUL:   st_nxt = CV_SCALE;
      CV_SCALE: st_nxt = CV_DIV;
      CV_DIV:   st_nxt = CV_IDLE;
      default:  st_nxt = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == CV_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == CV_IDLE && start) begin
      count_r <= count;
      unit_r  <= unit_select;
    end
    if (st_r == CV_MUL) begin
      big_r <= 24'(mul_p + 58'(off));
    end
    if (st_r == CV_SCALE) begin
      dvd_r <= scaled[pctr_pkg::DVD_W-1:0];
    end
    if (st_r == CV_DIV) begin
      quot_r <= mul_p[pctr_pkg::DIV_SHIFT+18:pctr_pkg::DIV_SHIFT];
    end
  end

  assign done        = done_r;
  assign temperature = quot_r - pctr_pkg::QUOT_BIAS;

endmodule

// ===== src/pulse_count_temperature_reader_core.sv =====
// Top level of the pulse-count temperature reader: ports, registers and result stage.
//
// One input transfer is one time tick: start_req, sensor_index and pulse_edge packed in
// in_tdata. Every tick gives exactly one result transfer on out_*: the one-hot sensor
// enable, busy, fault and the signed temperature in 1/256 degree, with out_tlast high on
// the tick that finishes a measurement.
// A tick that does not finish a measurement, or that finishes with a fault, is answered
// from the result register in the cycle after its transfer; without stalls one tick
// transfers per cycle. A tick that finishes with a valid count runs the converter: one
// scaling multiply, one unit multiply-add and a reciprocal multiply for the divide by
// 625, all on one shared multiplier. Its result passes through the converter's quotient
// and done registers into the result register; in_tready stays low until that result
// is loaded, so no new tick is taken before it.
// A tick is taken while the result register is empty or being drained, so a stalled
// result holds the input side too; nothing is dropped.
// Configuration writes on cfg_* are always ready and take effect at once.
// Reset (rst_n low, synchronous) returns the block to idle with the default register
// values: first pulse window 50000, gap 11, full count 3201, Celsius.
module pulse_count_temperature_reader_core #(
  parameter int SENSORS    = pctr_pkg::SENSORS_DEF,
  parameter int TIMER_BITS = pctr_pkg::TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // start_req, sensor_index[2:0], pulse_edge, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // enable_mask[7:0], busy_res, fault, temperature[18:0], pad
  output logic        out_tlast,  // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_TICK = 2'b01,
    ST_CONV = 2'b10
  } top_state_t;

  top_state_t       st_r;
  logic [15:0]      first_pulse_r, gap_r;
  logic [11:0]      max_count_r;
  logic [1:0]       unit_r;

  logic             out_valid_r;
  logic [7:0]       mask_r;
  logic             busy_r, done_r, fault_r;
  logic [18:0]      temp_r;

  logic             accept, conv_start, conv_done;
  logic [18:0]      conv_temp;
  pctr_pkg::tick_t  tick;

  assign in_tready  = (st_r == ST_TICK) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign conv_start = accept && tick.done && !tick.fault;
  assign cfg_ready  = 1'b1;

  pctr_ctrl #(
    .SENSORS    (SENSORS),
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .tick_en           (accept),
    .start_req         (in_tdata[0]),
    .sensor_index      (in_tdata[3:1]),
    .pulse_edge        (in_tdata[4]),
    .first_pulse_ticks (first_pulse_r),
    .gap_ticks         (gap_r),
    .max_count         (max_count_r),
    .tick              (tick)
  );

  pctr_conv u_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (conv_start),
    .count       (tick.count),
    .unit_select (unit_r),
    .done        (conv_done),
    .temperature (conv_temp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pulse_r <= pctr_pkg::FIRST_PULSE_RST;
      gap_r         <= pctr_pkg::GAP_RST;
      max_count_r   <= pctr_pkg::MAX_COUNT_RST;
      unit_r        <= pctr_pkg::UNIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pctr_pkg::cfg_reg_t'(cfg_index))
        pctr_pkg::REG_FIRST_PULSE: first_pulse_r <= cfg_data;
        pctr_pkg::REG_GAP:         gap_r         <= cfg_data;
        pctr_pkg::REG_MAX_COUNT:   max_count_r   <= cfg_data[11:0];
        pctr_pkg::REG_UNIT:        unit_r        <= cfg_data[1:0];
        default:                   unit_r        <= unit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_TICK;
      out_valid_r <= 1'b0;
    end else begin
      unique case (st_r)
        ST_TICK: if (conv_start) st_r <= ST_CONV;
        ST_CONV: if (conv_done) st_r <= ST_TICK;
        default: st_r <= ST_TICK;
      endcase
      if ((accept && !conv_start) || conv_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !conv_start) begin
      mask_r  <= tick.mask;
      busy_r  <= tick.busy;
      done_r  <= tick.done;
      fault_r <= tick.fault;
      temp_r  <= tick.fault ? pctr_pkg::FAULT_TEMP : '0;
    end else if (conv_done) begin
      mask_r  <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b1;
      fault_r <= 1'b0;
      temp_r  <= conv_temp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {3'd0, temp_r, fault_r, busy_r, mask_r};

endmodule

// ===== sim/pctr_checker.sv =====
`timescale 1ns / 1ps
// Checker: tracks the reader state per tick transfer, predicts each result and compares it.
module pctr_checker
  import pctr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_cnt,
  output int          pending,
  output phase_t      meas_phase
);

  typedef struct packed {
    logic [7:0]  mask;
    logic        busy;
    logic        done;
    logic        fault;
    logic [18:0] temp;
  } reading_t;

  logic [15:0] first_win  = FIRST_PULSE_RST;
  logic [15:0] gap_win    = GAP_RST;
  logic [11:0] full_count = MAX_COUNT_RST;
  logic [1:0]  unit_sel   = UNIT_RST;

  phase_t      phase  = PH_IDLE;
  logic [11:0] pulses = '0;
  logic [15:0] silent = '0;
  logic [2:0]  sensor = '0;

  reading_t readings_due[$];
  reading_t got;
  reading_t want;

  initial begin
    fail_cnt   = 0;
    pending    = 0;
    meas_phase = PH_IDLE;
  end

  function automatic logic [15:0] window_of(logic [15:0] r);
    return (r == 16'd0) ? 16'd1 : r;
  endfunction

  // signed 1/256 degree, rounded to nearest, from the pulse count
  function automatic logic [18:0] to_degrees(logic [11:0] c, logic [1:0] u);
    longint n;
    longint scaled;
    longint a;
    longint b;
    longint num;
    longint q;
    n = longint'(c) - 801;
    if (n < 480) scaled = 1005 * n - 2400;
    else if (n > 1600 && n < 2400) scaled = 988 * n + 19200;
    else scaled = 1000 * n;
    a = 10;
    b = 0;
    if (u == UNIT_F) begin
      a = 18;
      b = 5120000;
    end else if (u == UNIT_K) begin
      b = 43704000;
    end
    num = a * scaled + b + 312;
    q = num / 625;
    if ((num % 625) != 0 && num < 0) q = q - 1;
    return q[18:0];
  endfunction

  function automatic reading_t advance_tick(logic start, logic [2:0] idx, logic pulse);
    reading_t    r;
    logic        finish;
    logic        flt;
    logic [15:0] lim;
    r = '0;
    finish = 1'b0;
    flt = 1'b0;
    if (phase != PH_WAIT && phase != PH_COUNT) begin
      phase = PH_IDLE;
      if (start) begin
        sensor = idx;
        pulses = '0;
        silent = '0;
        phase  = PH_WAIT;
      end
    end else if (pulse) begin
      pulses = pulses + 12'd1;
      silent = '0;
      phase  = PH_COUNT;
      if (pulses >= full_count) finish = 1'b1;
    end else begin
      lim = window_of((phase == PH_WAIT) ? first_win : gap_win);
      if (silent != 16'hFFFF) silent = silent + 16'd1;
      if (silent >= lim) begin
        finish = 1'b1;
        if (phase == PH_WAIT) flt = 1'b1;
      end
    end
    if (finish) begin
      if (pulses < 12'd1 || pulses > FULL_SCALE) flt = 1'b1;
      r.temp = flt ? FAULT_TEMP : to_degrees(pulses, unit_sel);
      phase  = PH_IDLE;
    end
    r.mask  = (phase == PH_IDLE) ? 8'd0 : (8'd1 << sensor);
    r.busy  = (phase != PH_IDLE);
    r.done  = finish;
    r.fault = flt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      first_win  = FIRST_PULSE_RST;
      gap_win    = GAP_RST;
      full_count = MAX_COUNT_RST;
      unit_sel   = UNIT_RST;
      phase      = PH_IDLE;
      pulses     = '0;
      silent     = '0;
      sensor     = '0;
      readings_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.mask  = out_tdata[7:0];
        got.busy  = out_tdata[8];
        got.fault = out_tdata[9];
        got.temp  = out_tdata[28:10];
        got.done  = out_tlast;
        if (readings_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result transfer with none due: mask %h busy %b done %b fault %b temp %0d",
                     $realtime, got.mask, got.busy, got.done, got.fault, $signed(got.temp));
        end else begin
          want = readings_due.pop_front();
          if (got.mask !== want.mask || got.busy !== want.busy || got.done !== want.done ||
              got.fault !== want.fault || got.temp !== want.temp) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch exp mask %h busy %b done %b fault %b temp %0d, got mask %h busy %b done %b fault %b temp %0d",
                       $realtime, want.mask, want.busy, want.done, want.fault,
                       $signed(want.temp), got.mask, got.busy, got.done, got.fault,
                       $signed(got.temp));
          end
        end
      end
      if (in_tvalid && in_tready)
        readings_due.push_back(advance_tick(in_tdata[0], in_tdata[3:1], in_tdata[4]));
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_FIRST_PULSE: first_win  = cfg_data;
          REG_GAP:         gap_win    = cfg_data;
          REG_MAX_COUNT:   full_count = cfg_data[11:0];
          REG_UNIT:        unit_sel   = cfg_data[1:0];
          default: ;
        endcase
      end
    end
    pending    = readings_due.size();
    meas_phase = phase;
  end

endmodule

// ===== sim/tb_pulse_count_temperature_reader_core.sv =====
`timescale 1ns / 1ps
// Testbench top: drives ticks, register writes and back-pressure, and gives the verdict.
module tb_pulse_count_temperature_reader_core;
  import pctr_pkg::*;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_ready;

  int     fail_cnt;
  int     pending;
  phase_t meas_phase;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int ticks_sent      = 0;
  int first_lim       = 50000;
  int gap_lim         = 11;
  int send_pct[4]     = '{0, 75, 0, 8};
  int stall_pct[4]    = '{0, 0, 75, 8};
  int phase_start;

  pulse_count_temperature_reader_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pctr_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_cnt   (fail_cnt),
    .pending    (pending),
    .meas_phase (meas_phase)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);

  // one tick transfer; returns at the falling edge after it, valid still held
  task automatic send_tick(input logic start, input logic [2:0] idx, input logic pulse,
                           input bit tally);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, pulse, idx, start};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (tally) ticks_sent++;
  endtask

  task automatic quiet(input int n);
    repeat (n) send_tick($urandom_range(7, 0) == 0, 3'($urandom_range(7, 0)), 1'b0, 1'b1);
  endtask

  task automatic measure(input logic [2:0] idx, input int pre, input int count,
                         input int gap_hi, input int tail);
    send_tick(1'b1, idx, 1'($urandom_range(1, 0)), 1'b1);
    quiet(pre);
    for (int i = 0; i < count; i++) begin
      send_tick($urandom_range(7, 0) == 0, 3'($urandom_range(7, 0)), 1'b1, 1'b1);
      if (i < count - 1) quiet($urandom_range(gap_hi, 0));
    end
    quiet(tail);
  endtask

  // finish any measurement in flight, drop valid and drain the results
  task automatic settle();
    while (meas_phase != PH_IDLE)
      send_tick(1'b0, 3'($urandom_range(7, 0)), meas_phase == PH_WAIT, 1'b0);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] fp, input logic [15:0] gp,
                           input logic [11:0] mc, input logic [1:0] un);
    logic [15:0] junk;
    junk = $urandom;
    write_reg(REG_FIRST_PULSE, fp);
    write_reg(REG_GAP, gp);
    write_reg(REG_MAX_COUNT, {junk[15:12], mc});
    write_reg(REG_UNIT, {junk[15:2], un});
    cfg_valid <= 1'b0;
    first_lim = (fp == 16'd0) ? 1 : int'(fp);
    gap_lim   = (gp == 16'd0) ? 1 : int'(gp);
  endtask

  task automatic random_run();
    int kind;
    int r;
    int count;
    int hi;
    logic [2:0] idx;
    idx  = 3'($urandom_range(7, 0));
    kind = $urandom_range(99, 0);
    r    = $urandom_range(99, 0);
    if ($urandom_range(4, 0) == 0)
      repeat ($urandom_range(3, 1))
        send_tick(1'b0, 3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)), 1'b0);
    count = (r < 85) ? $urandom_range(40, 1) : $urandom_range(150, 41);
    if (kind < 8 && first_lim <= 200) begin
      measure(idx, first_lim, 0, 0, 0);
    end else if (kind < 20) begin
      hi = (gap_lim + 2 > 40) ? 40 : gap_lim + 2;
      measure(idx, $urandom_range((first_lim + 2 > 40) ? 40 : first_lim + 2, 0),
              $urandom_range(12, 1), hi, $urandom_range(hi, 0));
    end else begin
      measure(idx, $urandom_range((first_lim - 1 > 30) ? 30 : first_lim - 1, 0), count,
              (gap_lim - 1 > 6) ? 6 : gap_lim - 1, gap_lim);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle pulse, start-tick pulse, starts while busy, defaults
    send_tick(1'b0, 3'd5, 1'b1, 1'b0);
    measure(3'd0, 2, 3, 3, gap_lim);
    measure(3'd1, 0, 1, 0, gap_lim);
    settle();
    configure(16'd0, 16'd11, 12'd3201, UNIT_C);
    measure(3'd2, 1, 0, 0, 0);
    settle();
    configure(16'd1, 16'd3, 12'd0, UNIT_F);
    measure(3'd3, 0, 4, 1, gap_lim);
    settle();
    configure(16'd65535, 16'd2, 12'd1, 2'd3);
    measure(3'd4, 5, 2, 1, gap_lim);
    settle();
    // lower conversion knee
    configure(16'd100, 16'd1, 12'd4095, UNIT_F);
    measure(3'd6, 0, 1281, 0, 1);
    settle();
    configure(16'd20, 16'd40, 12'd4095, UNIT_C);
    measure(3'd7, 2, 2, 0, 40);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = send_pct[ph];
      recv_stall_pct  = stall_pct[ph];
      configure(($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(40, 0)),
                16'($urandom_range(40, 0)),
                ($urandom_range(1, 0) == 0) ? 12'($urandom) : 12'($urandom_range(30, 0)),
                2'($urandom_range(3, 0)));
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < 200) random_run();
      settle();
    end

    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
